>>> hdl/abmx_pkg.sv
package abmx_pkg;

	// Sample and coefficient formats.
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_BITS      = 16;
	localparam int COEF_FRAC_BITS = 14;
	localparam int NUM_CH         = 4;
	localparam int ROW_BITS       = NUM_CH * COEF_BITS;

	// Output gains are Q.15 and need one bit beyond 16 for the N3D value.
	localparam int GAIN_BITS = 17;
	localparam int GAIN_FRAC = 15;

	localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W   = PROD_W + 2;
	localparam int GPROD_W = SAMPLE_BITS + GAIN_BITS;
	localparam int SAT_IN_W = 64;

	// Output queue.
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MUTE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NORM   = 3'd7;
	localparam int CFG_DATA_W = 64;

	// Normalisation format codes.
	localparam logic [1:0] FMT_FUMA = 2'd0;
	localparam logic [1:0] FMT_N3D  = 2'd1;

	// Mode flag bit positions.
	localparam int MODE_MATRIX  = 0;
	localparam int MODE_ENDFIRE = 1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [GAIN_BITS-1:0]   gain_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [ACC_W-1:0]       acc_t;
	typedef logic signed [GPROD_W-1:0]     gprod_t;
	typedef logic signed [SAT_IN_W-1:0]    wide_t;
	typedef logic [ROW_BITS-1:0]           row_t;

	localparam gain_t GAIN_UNITY = 17'sd32768;
	localparam gain_t GAIN_FUMA  = 17'sd23170;
	localparam gain_t GAIN_N3D   = 17'sd56754;

	// One finished frame as it waits in the output queue.
	typedef struct packed {
		logic    last;
		sample_t z;
		sample_t y;
		sample_t x;
		sample_t w;
	} out_item_t;

	// Clamp a wide signed value to the sample range.
	function automatic sample_t sat(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = {{(SAT_IN_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			sat = hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			sat = lo[SAMPLE_BITS-1:0];
		end else begin
			sat = v[SAMPLE_BITS-1:0];
		end
	endfunction

	// Gain for one output channel; W is never inverted.
	function automatic gain_t gain_sel(input logic [1:0] fmt, input logic inv,
			input logic is_w);
		gain_t g;
		g = GAIN_UNITY;
		if (is_w && fmt == FMT_FUMA) begin
			g = GAIN_FUMA;
		end else if (!is_w && fmt == FMT_N3D) begin
			g = GAIN_N3D;
		end
		if (inv && !is_w) begin
			g = -g;
		end
		gain_sel = g;
	endfunction

endpackage

>>> hdl/ambisonic_a_to_b_matrix_core.sv
// A-format to B-format conversion for a four-capsule microphone.
// The s_ channel carries one frame per transfer: four signed 24-bit capsule
// samples in s_tdata and the end-of-block mark in s_tlast. The m_ channel
// returns the W, X, Y and Z samples of that frame, with m_tlast copied over.
// The cfg_ channel writes one register per transfer (index and 64-bit data);
// cfg_ready is always high, and writes are expected only while the block is
// idle.
// An input transfer reaches m_tvalid through the product, row-sum and gain
// registers, then the write into the queue. Throughput is one frame per
// cycle while s_tready is high, set by the three-stage multiplier pipeline,
// which never stalls: every accepted frame finishes and lands in an
// eight-entry output queue. s_tready stays high while fewer than eight
// frames are in flight or queued, so a stalled receiver fills the queue and
// only then holds off the sender; nothing is dropped.
// Reset clears the pipeline valid flags and the queue, and loads the
// identity matrix, no muting, no inversion, matrix and end-fire off, and
// FuMa normalisation.
module ambisonic_a_to_b_matrix_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// in_ch0, in_ch1, in_ch2, in_ch3 from bit 0 up, 24 bits each
	input  logic [4*abmx_pkg::SAMPLE_BITS-1:0]  s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_w, out_x, out_y, out_z from bit 0 up, 24 bits each
	output logic [4*abmx_pkg::SAMPLE_BITS-1:0]  m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [abmx_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [abmx_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Configuration registers.
	abmx_pkg::row_t row_q [abmx_pkg::NUM_CH];
	logic [3:0] mute_q;
	logic [3:0] invert_q;
	logic [1:0] mode_q;
	logic [1:0] norm_q;

	// Pipeline control.
	logic v_s1, v_s2, v_s3;
	logic last_s1, last_s2, last_s3;

	// Output queue.
	abmx_pkg::out_item_t fifo_q [abmx_pkg::FIFO_DEPTH];
	logic [abmx_pkg::PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [abmx_pkg::CNT_W-1:0] fifo_cnt_q;
	logic [abmx_pkg::CNT_W-1:0] pend_cnt_q;

	logic in_xfer, out_xfer, cfg_xfer;

	abmx_pkg::sample_t x_in [abmx_pkg::NUM_CH];
	abmx_pkg::sample_t y_s2 [abmx_pkg::NUM_CH];
	abmx_pkg::sample_t y_ef [abmx_pkg::NUM_CH];
	abmx_pkg::sample_t res [abmx_pkg::NUM_CH];
	abmx_pkg::gain_t   gain [abmx_pkg::NUM_CH];
	abmx_pkg::out_item_t head;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign in_xfer   = s_tvalid & s_tready;
	assign out_xfer  = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 64'h0000_0000_0000_4000;
			row_q[1] <= 64'h0000_0000_4000_0000;
			row_q[2] <= 64'h0000_4000_0000_0000;
			row_q[3] <= 64'h4000_0000_0000_0000;
			mute_q   <= '0;
			invert_q <= '0;
			mode_q   <= '0;
			norm_q   <= abmx_pkg::FMT_FUMA;
		end else if (cfg_xfer) begin
			unique case (cfg_index)
				abmx_pkg::REG_ROW0:   row_q[0] <= cfg_data;
				abmx_pkg::REG_ROW1:   row_q[1] <= cfg_data;
				abmx_pkg::REG_ROW2:   row_q[2] <= cfg_data;
				abmx_pkg::REG_ROW3:   row_q[3] <= cfg_data;
				abmx_pkg::REG_MUTE:   mute_q   <= cfg_data[3:0];
				abmx_pkg::REG_INVERT: invert_q <= cfg_data[3:0];
				abmx_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				abmx_pkg::REG_NORM:   norm_q   <= cfg_data[1:0];
			endcase
		end
	end

	// Muting happens on the way into the product stage.
	always_comb begin
		for (int k = 0; k < abmx_pkg::NUM_CH; k++) begin
			x_in[k] = mute_q[k] ? '0
				: s_tdata[k*abmx_pkg::SAMPLE_BITS +: abmx_pkg::SAMPLE_BITS];
		end
	end

	// One multiply-accumulate lane per output row.
	for (genvar i = 0; i < abmx_pkg::NUM_CH; i++) begin : g_mac
		abmx_mac_lane u_mac (
			.clk    (clk),
			.x      (x_in),
			.x_own  (x_in[i]),
			.row    (row_q[i]),
			.mat_en (mode_q[abmx_pkg::MODE_MATRIX]),
			.y_s2   (y_s2[i])
		);
	end

	// Merge of the lane results: the end-fire swap moves Z into X and the
	// negated X into Z, with the negation clamped at full scale.
	always_comb begin
		y_ef[0] = y_s2[0];
		y_ef[2] = y_s2[2];
		if (mode_q[abmx_pkg::MODE_ENDFIRE]) begin
			y_ef[1] = y_s2[3];
			y_ef[3] = abmx_pkg::sat(-abmx_pkg::SAT_IN_W'(y_s2[1]));
		end else begin
			y_ef[1] = y_s2[1];
			y_ef[3] = y_s2[3];
		end
	end

	// Normalisation and inversion, one gain lane per output channel.
	for (genvar i = 0; i < abmx_pkg::NUM_CH; i++) begin : g_gain
		assign gain[i] = abmx_pkg::gain_sel(norm_q, invert_q[i], i == 0);

		abmx_gain_lane u_gain (
			.clk  (clk),
			.y    (y_ef[i]),
			.gain (gain[i]),
			.res  (res[i])
		);
	end

	// The pipeline never stalls, so only the valid flags need a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= s_tlast;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_q[wr_ptr_q] <= '{last: last_s3, z: res[3], y: res[2], x: res[1],
				w: res[0]};
		end
	end

	// The pending count covers frames in the pipeline and in the queue, so
	// a frame is only accepted when the queue is sure to have room for it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			pend_cnt_q <= '0;
		end else begin
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_xfer) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + abmx_pkg::CNT_W'(v_s3)
				- abmx_pkg::CNT_W'(out_xfer);
			pend_cnt_q <= pend_cnt_q + abmx_pkg::CNT_W'(in_xfer)
				- abmx_pkg::CNT_W'(out_xfer);
		end
	end

	assign s_tready = (pend_cnt_q != abmx_pkg::CNT_W'(abmx_pkg::FIFO_DEPTH));
	assign m_tvalid = (fifo_cnt_q != '0);
	assign head     = fifo_q[rd_ptr_q];
	assign m_tdata  = {head.z, head.y, head.x, head.w};
	assign m_tlast  = head.last;

endmodule

>>> hdl/abmx_mac_lane.sv
module abmx_mac_lane (
	input  logic                clk,
	input  abmx_pkg::sample_t   x [abmx_pkg::NUM_CH],
	input  abmx_pkg::sample_t   x_own,
	input  abmx_pkg::row_t      row,
	input  logic                mat_en,
	output abmx_pkg::sample_t   y_s2
);

	abmx_pkg::prod_t   prod_s1 [abmx_pkg::NUM_CH];
	abmx_pkg::sample_t own_s1;
	abmx_pkg::acc_t    acc;
	abmx_pkg::acc_t    rnd;
	abmx_pkg::acc_t    shifted;
	abmx_pkg::acc_t    half;

	// First stage: the four coefficient products of this output row.
	always_ff @(posedge clk) begin
		for (int k = 0; k < abmx_pkg::NUM_CH; k++) begin
			prod_s1[k] <= $signed(row[k*abmx_pkg::COEF_BITS +: abmx_pkg::COEF_BITS])
				* $signed(x[k]);
		end
		own_s1 <= x_own;
	end

	assign half = {{(abmx_pkg::ACC_W-abmx_pkg::COEF_FRAC_BITS){1'b0}}, 1'b1,
		{(abmx_pkg::COEF_FRAC_BITS-1){1'b0}}};

	always_comb begin
		acc = '0;
		for (int k = 0; k < abmx_pkg::NUM_CH; k++) begin
			acc = acc + abmx_pkg::ACC_W'(prod_s1[k]);
		end
		rnd     = acc + half;
		shifted = rnd >>> abmx_pkg::COEF_FRAC_BITS;
	end

	// Second stage: rounded, clamped row sum, or the muted input unchanged.
	always_ff @(posedge clk) begin
		if (mat_en) begin
			y_s2 <= abmx_pkg::sat(abmx_pkg::SAT_IN_W'(shifted));
		end else begin
			y_s2 <= own_s1;
		end
	end

endmodule

>>> hdl/abmx_gain_lane.sv
module abmx_gain_lane (
	input  logic                clk,
	input  abmx_pkg::sample_t   y,
	input  abmx_pkg::gain_t     gain,
	output abmx_pkg::sample_t   res
);

	abmx_pkg::gprod_t gprod_s3;
	abmx_pkg::gprod_t half;
	abmx_pkg::gprod_t rnd;
	abmx_pkg::gprod_t shifted;

	always_ff @(posedge clk) begin
		gprod_s3 <= y * gain;
	end

	assign half = {{(abmx_pkg::GPROD_W-abmx_pkg::GAIN_FRAC){1'b0}}, 1'b1,
		{(abmx_pkg::GAIN_FRAC-1){1'b0}}};
	assign rnd     = gprod_s3 + half;
	assign shifted = rnd >>> abmx_pkg::GAIN_FRAC;
	assign res     = abmx_pkg::sat(abmx_pkg::SAT_IN_W'(shifted));

endmodule

>>> dv/ambisonic_a_to_b_matrix_core_tb.sv
`timescale 1ns / 100ps

module ambisonic_a_to_b_matrix_core_tb;

	localparam int     SB           = abmx_pkg::SAMPLE_BITS;
	localparam longint SMAX         = 64'sd8388607;
	localparam longint SMIN         = -64'sd8388608;
	localparam int     PIPE_LATENCY = 4;
	localparam int     DRAIN_LIMIT  = 2000;
	localparam int     CYCLE_LIMIT  = 400000;
	localparam int     NUM_PHASES   = 10;

	// Output gains in Q.15, kept apart from the design's own constants.
	localparam longint Q15_ONE  = 32768;
	localparam longint Q15_FUMA = 23170;
	localparam longint Q15_N3D  = 56754;
	localparam int     Q15_FRAC = 15;

	// Format codes that the package leaves unnamed: both mean no gain.
	localparam logic [1:0] FMT_UNITY = 2'd2;
	localparam logic [1:0] FMT_SPARE = 2'd3;

	localparam logic [abmx_pkg::CFG_IDX_W-1:0] ALL_REGS [8] = '{abmx_pkg::REG_ROW0,
		abmx_pkg::REG_ROW1, abmx_pkg::REG_ROW2, abmx_pkg::REG_ROW3,
		abmx_pkg::REG_MUTE, abmx_pkg::REG_INVERT, abmx_pkg::REG_MODE,
		abmx_pkg::REG_NORM};

	typedef struct {
		abmx_pkg::sample_t ch [4];
		logic              last;
	} aframe_t;

	typedef struct {
		abmx_pkg::sample_t w;
		abmx_pkg::sample_t x;
		abmx_pkg::sample_t y;
		abmx_pkg::sample_t z;
		logic              last;
	} bframe_t;

	// One line of the directed script: either a register write or a frame,
	// the latter with its result typed in where it is obvious.
	typedef struct {
		logic                            is_cfg;
		logic [abmx_pkg::CFG_IDX_W-1:0]  idx;
		logic [abmx_pkg::CFG_DATA_W-1:0] val;
		aframe_t                         fr;
		logic                            has_exp;
		bframe_t                         exp_out;
	} script_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [4*SB-1:0]                     s_tdata;
	logic                                s_tlast;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [4*SB-1:0]                     m_tdata;
	logic                                m_tlast;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [abmx_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [abmx_pkg::CFG_DATA_W-1:0]     cfg_data;

	// Our copy of the register file, updated on each accepted write.
	abmx_pkg::row_t row_cfg [4];
	logic [3:0] mute_cfg;
	logic [3:0] invert_cfg;
	logic [1:0] mode_cfg;
	logic [1:0] norm_cfg;

	bframe_t     pending_bframes [$];
	script_row_t directed_rows [$];

	int errors;
	int cycles;
	int frames_directed;
	int frames_random;
	int results_checked;
	int reg_writes;

	ambisonic_a_to_b_matrix_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic longint clamp_sample(input longint v);
		if (v > SMAX) begin
			return SMAX;
		end else if (v < SMIN) begin
			return SMIN;
		end
		return v;
	endfunction

	// Add half an LSB, then shift right with floor: round half up.
	function automatic longint round_shr(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	// Works out the B-format frame for one capsule frame under the
	// current register settings. Every stage saturates to the sample width.
	function automatic bframe_t convert_frame(input aframe_t f);
		longint          cap [4];
		longint          mix [4];
		longint          gain [4];
		longint          acc;
		longint          held;
		abmx_pkg::coef_t c;
		bframe_t         r;
		for (int i = 0; i < 4; i++) begin
			cap[i] = f.ch[i];
			if (mute_cfg[i]) begin
				cap[i] = 0;
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (mode_cfg[abmx_pkg::MODE_MATRIX]) begin
				acc = 0;
				for (int k = 0; k < 4; k++) begin
					c = row_cfg[i][16*k +: 16];
					acc += c * cap[k];
				end
				mix[i] = clamp_sample(round_shr(acc, abmx_pkg::COEF_FRAC_BITS));
			end else begin
				mix[i] = cap[i];
			end
		end
		// End-fire: X takes old Z, Z takes the negated old X.
		if (mode_cfg[abmx_pkg::MODE_ENDFIRE]) begin
			held   = mix[1];
			mix[1] = mix[3];
			mix[3] = clamp_sample(-held);
		end
		for (int i = 0; i < 4; i++) begin
			gain[i] = Q15_ONE;
		end
		if (norm_cfg == abmx_pkg::FMT_FUMA) begin
			gain[0] = Q15_FUMA;
		end else if (norm_cfg == abmx_pkg::FMT_N3D) begin
			for (int i = 1; i < 4; i++) begin
				gain[i] = Q15_N3D;
			end
		end
		// W can never be inverted, whatever bit 0 of the mask says.
		for (int i = 1; i < 4; i++) begin
			if (invert_cfg[i]) begin
				gain[i] = -gain[i];
			end
		end
		for (int i = 0; i < 4; i++) begin
			mix[i] = clamp_sample(round_shr(mix[i] * gain[i], Q15_FRAC));
		end
		r.w    = abmx_pkg::sample_t'(mix[0]);
		r.x    = abmx_pkg::sample_t'(mix[1]);
		r.y    = abmx_pkg::sample_t'(mix[2]);
		r.z    = abmx_pkg::sample_t'(mix[3]);
		r.last = f.last;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed script construction
	// ------------------------------------------------------------------

	function automatic aframe_t make_aframe(input longint c0, input longint c1,
			input longint c2, input longint c3, input logic last);
		aframe_t f;
		f.ch[0] = abmx_pkg::sample_t'(c0);
		f.ch[1] = abmx_pkg::sample_t'(c1);
		f.ch[2] = abmx_pkg::sample_t'(c2);
		f.ch[3] = abmx_pkg::sample_t'(c3);
		f.last  = last;
		return f;
	endfunction

	function automatic void script_cfg(input logic [abmx_pkg::CFG_IDX_W-1:0] idx,
			input logic [abmx_pkg::CFG_DATA_W-1:0] val);
		script_row_t r;
		r         = '{default: '0};
		r.is_cfg  = 1'b1;
		r.idx     = idx;
		r.val     = val;
		directed_rows.push_back(r);
	endfunction

	function automatic void script_frame(input longint c0, input longint c1,
			input longint c2, input longint c3, input logic last);
		script_row_t r;
		r    = '{default: '0};
		r.fr = make_aframe(c0, c1, c2, c3, last);
		directed_rows.push_back(r);
	endfunction

	function automatic void script_checked(input longint c0, input longint c1,
			input longint c2, input longint c3, input logic last, input longint w,
			input longint x, input longint y, input longint z);
		script_row_t r;
		r                = '{default: '0};
		r.fr             = make_aframe(c0, c1, c2, c3, last);
		r.has_exp        = 1'b1;
		r.exp_out.w      = abmx_pkg::sample_t'(w);
		r.exp_out.x      = abmx_pkg::sample_t'(x);
		r.exp_out.y      = abmx_pkg::sample_t'(y);
		r.exp_out.z      = abmx_pkg::sample_t'(z);
		r.exp_out.last   = last;
		directed_rows.push_back(r);
	endfunction

	// ------------------------------------------------------------------
	// Random choices
	// ------------------------------------------------------------------

	function automatic abmx_pkg::sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return abmx_pkg::sample_t'(SMAX);
			1: return abmx_pkg::sample_t'(SMIN);
			2: return '0;
			3: return abmx_pkg::sample_t'($urandom_range(0, 512))
				- abmx_pkg::sample_t'(256);
			default: return abmx_pkg::sample_t'($urandom);
		endcase
	endfunction

	function automatic aframe_t pick_aframe();
		aframe_t f;
		for (int i = 0; i < 4; i++) begin
			f.ch[i] = pick_sample();
		end
		f.last = ($urandom_range(0, 7) == 0);
		return f;
	endfunction

	// Mostly gains within plus or minus one, with the odd full-range value.
	function automatic abmx_pkg::coef_t pick_coef();
		case ($urandom_range(0, 3))
			0: return abmx_pkg::coef_t'($urandom);
			1: return $urandom_range(0, 1) ? abmx_pkg::coef_t'(16'h4000)
				: abmx_pkg::coef_t'(16'hC000);
			default: return abmx_pkg::coef_t'($urandom_range(0, 32768))
				- abmx_pkg::coef_t'(16384);
		endcase
	endfunction

	function automatic abmx_pkg::row_t pick_row();
		abmx_pkg::row_t r;
		case ($urandom_range(0, 5))
			0: r = {4{16'h7FFF}};
			1: r = {4{16'h8000}};
			2: r = '0;
			default: begin
				for (int k = 0; k < 4; k++) begin
					r[16*k +: 16] = pick_coef();
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [3:0] pick_mask();
		case ($urandom_range(0, 3))
			0: return 4'h0;
			1: return 4'hF;
			default: return 4'($urandom);
		endcase
	endfunction

	// Narrow registers get random junk above their used bits.
	function automatic logic [abmx_pkg::CFG_DATA_W-1:0] pick_reg_value(
			input logic [abmx_pkg::CFG_IDX_W-1:0] idx);
		logic [abmx_pkg::CFG_DATA_W-1:0] junk;
		logic [1:0]                      fmt;
		junk = {$urandom, $urandom};
		case (idx)
			abmx_pkg::REG_ROW0, abmx_pkg::REG_ROW1, abmx_pkg::REG_ROW2,
			abmx_pkg::REG_ROW3: return pick_row();
			abmx_pkg::REG_MUTE, abmx_pkg::REG_INVERT:
				return {junk[abmx_pkg::CFG_DATA_W-1:4], pick_mask()};
			abmx_pkg::REG_MODE: return {junk[abmx_pkg::CFG_DATA_W-1:2], 2'($urandom)};
			default: begin
				case ($urandom_range(0, 3))
					0: fmt = abmx_pkg::FMT_FUMA;
					1: fmt = abmx_pkg::FMT_N3D;
					2: fmt = FMT_UNITY;
					default: fmt = FMT_SPARE;
				endcase
				return {junk[abmx_pkg::CFG_DATA_W-1:2], fmt};
			end
		endcase
	endfunction

	// Sender gaps: usually short, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 4);
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Drives one frame and waits for its transfer, then files the result
	// we expect from it.
	task automatic send_frame(input aframe_t f, input bframe_t want);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {f.ch[3], f.ch[2], f.ch[1], f.ch[0]};
		s_tlast  <= f.last;
		do @(posedge clk); while (!s_tready);
		pending_bframes.push_back(want);
	endtask

	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	// Stops the sender and waits until every frame in flight has come
	// back, then lets the pipeline run empty before anything else happens.
	task automatic drain_pipeline();
		int waited;
		waited = 0;
		hold_off(1);
		while (pending_bframes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_bframes.size() != 0) begin
			$error("%0d expected results never arrived", pending_bframes.size());
			errors++;
			pending_bframes.delete();
		end
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [abmx_pkg::CFG_IDX_W-1:0] idx,
			input logic [abmx_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			abmx_pkg::REG_ROW0:   row_cfg[0] = val;
			abmx_pkg::REG_ROW1:   row_cfg[1] = val;
			abmx_pkg::REG_ROW2:   row_cfg[2] = val;
			abmx_pkg::REG_ROW3:   row_cfg[3] = val;
			abmx_pkg::REG_MUTE:   mute_cfg   = val[3:0];
			abmx_pkg::REG_INVERT: invert_cfg = val[3:0];
			abmx_pkg::REG_MODE:   mode_cfg   = val[1:0];
			default:              norm_cfg   = val[1:0];
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver: its ready follows one of several stall patterns, and a new
	// pattern is picked at random each time the current one runs out.
	// ------------------------------------------------------------------

	int rx_mode;
	int rx_left;
	int rx_tick;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(64, 256);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((rx_tick % 11) < 7);
		endcase
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	bframe_t oldest;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bframes.size() == 0) begin
				$error("result transfer with no frame outstanding");
				errors++;
			end else begin
				oldest = pending_bframes.pop_front();
				check_field("out_w", oldest.w, abmx_pkg::sample_t'(m_tdata[0*SB +: SB]));
				check_field("out_x", oldest.x, abmx_pkg::sample_t'(m_tdata[1*SB +: SB]));
				check_field("out_y", oldest.y, abmx_pkg::sample_t'(m_tdata[2*SB +: SB]));
				check_field("out_z", oldest.z, abmx_pkg::sample_t'(m_tdata[3*SB +: SB]));
				check_field("out_last", oldest.last, m_tlast);
				results_checked++;
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycles, pending_bframes.size());
			$display("[ambisonic_a_to_b_matrix_core] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	initial begin
		aframe_t     f;
		bframe_t     want;
		script_row_t r;
		int          count;
		int          burst_left;
		bit          gaps_on;

		errors          = 0;
		cycles          = 0;
		frames_directed = 0;
		frames_random   = 0;
		results_checked = 0;
		reg_writes      = 0;
		rx_mode         = 0;
		rx_left         = 0;
		rx_tick         = 0;
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tlast         = 1'b0;
		m_tready        = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;

		// Register values after reset: identity matrix, FuMa, all else off.
		row_cfg[0] = 64'd16384;
		row_cfg[1] = 64'd1073741824;
		row_cfg[2] = 64'd70368744177664;
		row_cfg[3] = 64'd4611686018427387904;
		mute_cfg   = '0;
		invert_cfg = '0;
		mode_cfg   = '0;
		norm_cfg   = abmx_pkg::FMT_FUMA;

		// Directed script. Straight after reset the frame passes through
		// with only the W gain, so zeros stay zeros.
		script_checked(0, 0, 0, 0, 1'b0, 0, 0, 0, 0);
		script_frame(SMAX, SMAX, SMAX, SMAX, 1'b1);
		script_frame(SMIN, SMIN, SMIN, SMIN, 1'b0);
		// With no gain anywhere the extremes come back untouched.
		script_cfg(abmx_pkg::REG_NORM, FMT_UNITY);
		script_checked(SMAX, SMAX, SMAX, SMAX, 1'b1, SMAX, SMAX, SMAX, SMAX);
		script_checked(SMIN, SMIN, SMIN, SMIN, 1'b0, SMIN, SMIN, SMIN, SMIN);
		// Inversion at unity gain is a saturating negation; bit 0 does nothing.
		script_cfg(abmx_pkg::REG_INVERT, 4'hF);
		script_checked(SMIN, SMIN, SMIN, SMIN, 1'b0, SMIN, SMAX, SMAX, SMAX);
		script_checked(1, -1, 5, -7, 1'b1, 1, 1, -5, 7);
		// End-fire swap, including the negation of the most negative sample.
		script_cfg(abmx_pkg::REG_INVERT, 4'h0);
		script_cfg(abmx_pkg::REG_MODE, 2'b10);
		script_checked(0, SMIN, 3, 9, 1'b0, 0, 9, 3, SMAX);
		script_checked(4, SMAX, -2, SMIN, 1'b1, 4, SMIN, -2, -SMAX);
		// Identity matrix leaves the frame as it is.
		script_cfg(abmx_pkg::REG_MODE, 2'b01);
		script_checked(SMAX, SMIN, 123, -456, 1'b0, SMAX, SMIN, 123, -456);
		// Largest positive and negative coefficients drive the sums to the rails.
		script_cfg(abmx_pkg::REG_ROW0, {4{16'h7FFF}});
		script_checked(SMAX, SMAX, SMAX, SMAX, 1'b0, SMAX, SMAX, SMAX, SMAX);
		script_cfg(abmx_pkg::REG_ROW1, {4{16'h8000}});
		script_checked(SMAX, SMAX, SMAX, SMAX, 1'b1, SMAX, SMIN, SMAX, SMAX);
		script_checked(SMIN, SMIN, SMIN, SMIN, 1'b0, SMIN, SMAX, SMIN, SMIN);
		// Every channel muted gives silence whatever the coefficients.
		script_cfg(abmx_pkg::REG_MUTE, 4'hF);
		script_checked(SMAX, SMIN, SMAX, SMIN, 1'b1, 0, 0, 0, 0);
		script_cfg(abmx_pkg::REG_MUTE, 4'b0101);
		script_frame(1000, -2000, 3000, -4000, 1'b0);
		script_cfg(abmx_pkg::REG_NORM, abmx_pkg::FMT_N3D);
		script_frame(-12345, 67890, 5, -1, 1'b1);
		script_frame(SMAX, SMIN, SMAX, SMIN, 1'b0);
		// The spare format code behaves as unity.
		script_cfg(abmx_pkg::REG_NORM, FMT_SPARE);
		script_frame(100, 200, 300, 400, 1'b0);
		script_cfg(abmx_pkg::REG_MODE, 2'b11);
		script_frame(SMAX, -1, SMIN, 77, 1'b1);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.is_cfg) begin
				drain_pipeline();
				write_reg(r.idx, r.val);
			end else begin
				want = r.has_exp ? r.exp_out : convert_frame(r.fr);
				send_frame(r.fr, want);
				frames_directed++;
			end
		end

		// Random part: each phase starts from an idle block, rewrites some
		// registers (all of them the first time) and then streams frames in
		// bursts. Some phases run with no sender gaps at all.
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_pipeline();
			foreach (ALL_REGS[k]) begin
				if (phase == 0 || $urandom_range(0, 1)) begin
					write_reg(ALL_REGS[k], pick_reg_value(ALL_REGS[k]));
				end
			end
			count      = 100 + $urandom_range(0, 10);
			gaps_on    = ($urandom_range(0, 3) != 0);
			burst_left = 0;
			for (int n = 0; n < count; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					if (gaps_on) begin
						hold_off(pick_gap());
					end
				end
				// Once in a while the sender waits for every result mid-phase.
				if (n == count / 2 && (phase % 3) == 1) begin
					drain_pipeline();
				end
				f = pick_aframe();
				send_frame(f, convert_frame(f));
				frames_random++;
				burst_left--;
			end
		end

		drain_pipeline();

		$display("Covered %0d directed and %0d random frames, %0d register writes.",
			frames_directed, frames_random, reg_writes);
		$display("Compared %0d result transfers, %0d mismatches or losses.",
			results_checked, errors);
		if (errors == 0) begin
			$display("[ambisonic_a_to_b_matrix_core] OK");
		end else begin
			$display("[ambisonic_a_to_b_matrix_core] ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/abmx_pkg.sv
hdl/abmx_mac_lane.sv
hdl/abmx_gain_lane.sv
hdl/ambisonic_a_to_b_matrix_core.sv
dv/ambisonic_a_to_b_matrix_core_tb.sv
